### rtl/pec_pkg.sv
package pec_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // One queued job: a single result, or a byte to be sent as a three-byte escape
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       bad;
    logic       last;
    logic       triple;
  } job_t;

  typedef struct packed {
    logic mid_triple;
  } back_status_t;

  // Bit 4 set means the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end
    return v;
  endfunction

  function automatic logic needs_escape(input logic [7:0] c);
    return (c == CH_PERCENT) || (c == CH_COMMA) || (c == CH_SEMI) ||
           (c == CH_SPACE) || (c == CH_NEWLINE);
  endfunction

  function automatic logic [7:0] hex_lower(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'h0, n};
    end else begin
      r = 8'h57 + {4'h0, n};
    end
    return r;
  endfunction

endpackage

### rtl/percent_escape_codec_core.sv
// Flow: an accepted transaction that yields a job is written to the queue, and each
// result of the job reaches the out_ ports through the back end's result register.
// Rate: one input per cycle while in_full is low; a byte sent as an escape yields
// three results, and the back end's single result register emits one result per
// cycle while out_pop drains it. Reset (rst_n low, synchronous): direction returns
// to encode, escape state, queue and result register are cleared.
module percent_escape_codec_core
  import pec_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_direction,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_string,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_out_byte,
  output logic       out_byte_present,
  output logic       out_bad,
  output logic       out_last_out
);

  logic         q_push, q_full, q_pop, q_empty;
  job_t         q_in_job, q_head_job;
  back_status_t back_st;

  pec_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_direction    (cfg_direction),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_job            (q_in_job)
  );

  pec_queue #(.DEPTH(DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (q_head_job),
    .empty    (q_empty)
  );

  pec_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_job            (q_head_job),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_out_byte     (out_out_byte),
    .out_byte_present (out_byte_present),
    .out_bad          (out_bad),
    .out_last_out     (out_last_out),
    .st               (back_st)
  );

  // An escape under way keeps its job at the queue head until the last digit
  a_mid_triple_held: assert property (@(posedge clk) disable iff (!rst_n)
    back_st.mid_triple |-> !q_empty)
    else $error("escape in progress with empty queue");

  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_bad) |-> (out_last_out && !out_byte_present))
    else $error("bad result not a bare last result");

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue both full and empty");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

### rtl/pec_front.sv
module pec_front
  import pec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_direction,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_string,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_SECOND
  } phase_t;

  logic       dir_r;
  phase_t     phase_r, phase_nxt;
  logic [3:0] nib_r, nib_nxt;
  logic       err_r, err_nxt;
  logic       accept;
  logic       job_push;
  logic [4:0] hv;
  logic       have_byte;
  logic [7:0] produced;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push & ~q_full;
  assign q_push    = accept & job_push;
  assign hv        = hex_value(in_data_byte);

  always_comb begin
    phase_nxt = phase_r;
    nib_nxt   = nib_r;
    err_nxt   = err_r;
    job_push  = 1'b0;
    have_byte = 1'b0;
    produced  = 8'h00;
    q_job     = '0;
    if (dir_r == DIR_ENCODE) begin
      q_job.data    = in_data_byte;
      q_job.present = 1'b1;
      q_job.last    = in_end_of_string;
      q_job.triple  = needs_escape(in_data_byte);
      job_push      = 1'b1;
    end else begin
      if (!err_r) begin
        unique case (phase_r)
          PH_FIRST: begin
            if (!hv[4]) begin
              nib_nxt   = hv[3:0];
              phase_nxt = PH_SECOND;
            end else begin
              err_nxt = 1'b1;
            end
          end
          PH_SECOND: begin
            if (!hv[4]) begin
              produced  = {nib_r, hv[3:0]};
              have_byte = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              err_nxt = 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            if (in_data_byte == CH_PERCENT) begin
              phase_nxt = PH_FIRST;
            end else begin
              produced  = in_data_byte;
              have_byte = 1'b1;
            end
          end
        endcase
      end
      if (in_end_of_string) begin
        job_push = 1'b1;
        q_job.last = 1'b1;
        if (err_nxt || phase_nxt != PH_IDLE) begin
          q_job.bad = 1'b1;
        end else begin
          q_job.data    = produced;
          q_job.present = have_byte;
        end
      end else begin
        job_push      = have_byte;
        q_job.data    = produced;
        q_job.present = 1'b1;
      end
    end
    // End of string clears the escape state in either mode
    if (in_end_of_string) begin
      phase_nxt = PH_IDLE;
      nib_nxt   = 4'h0;
      err_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= DIR_ENCODE;
      phase_r <= PH_IDLE;
      nib_r   <= 4'h0;
      err_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        dir_r <= cfg_direction;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        nib_r   <= nib_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

### rtl/pec_queue.sv
module pec_queue
  import pec_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head_job,
  output logic empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  job_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign head_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/pec_back.sv
module pec_back
  import pec_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  input  job_t         q_job,
  output logic         q_pop,
  output logic         out_empty,
  input  logic         out_pop,
  output logic [7:0]   out_out_byte,
  output logic         out_byte_present,
  output logic         out_bad,
  output logic         out_last_out,
  output back_status_t st
);

  typedef enum logic [1:0] {
    ST_FIRST,
    ST_SECOND,
    ST_THIRD
  } step_t;

  step_t      step_r, step_nxt;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       present_r, bad_r, last_r;
  logic       load;
  logic [7:0] res_byte;
  logic       res_present, res_bad, res_last;

  assign out_empty        = ~valid_r;
  assign out_out_byte     = byte_r;
  assign out_byte_present = present_r;
  assign out_bad          = bad_r;
  assign out_last_out     = last_r;
  assign st.mid_triple    = (step_r != ST_FIRST);

  assign load  = (~valid_r | out_pop) & ~q_empty;
  assign q_pop = load & (~q_job.triple | (step_r == ST_THIRD));

  always_comb begin
    res_byte    = q_job.data;
    res_present = q_job.present;
    res_bad     = q_job.bad;
    res_last    = q_job.last;
    step_nxt    = step_r;
    if (q_job.triple) begin
      res_present = 1'b1;
      res_bad     = 1'b0;
      unique case (step_r)
        ST_FIRST: begin
          res_byte = CH_PERCENT;
          res_last = 1'b0;
          step_nxt = ST_SECOND;
        end
        ST_SECOND: begin
          res_byte = hex_lower(q_job.data[7:4]);
          res_last = 1'b0;
          step_nxt = ST_THIRD;
        end
        default: begin
          res_byte = hex_lower(q_job.data[3:0]);
          step_nxt = ST_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_FIRST;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        step_r    <= step_nxt;
        valid_r   <= 1'b1;
        byte_r    <= res_byte;
        present_r <= res_present;
        bad_r     <= res_bad;
        last_r    <= res_last;
      end else if (out_pop) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule
